[rtl/gdd_pkg.sv]
// Types, constants and calendar tables for the Gregorian day difference block.
// No dependencies; used by gdd_date_num and gregorian_day_difference.
`default_nettype none

package gdd_pkg;

    localparam int DayW  = 5;
    localparam int MonW  = 4;
    localparam int YearW = 14;
    localparam int DistW = 22;
    // Shifted year (year + 399) and day numbers of shifted years
    localparam int YsW   = 15;
    localparam int NumW  = 23;
    localparam int OffW  = 13;

    // 400-year shift minus one, applied before the whole-year count
    localparam logic [YsW-1:0]   YearBias    = 15'd399;
    localparam logic [8:0]       DaysPerYear = 9'd365;
    // floor(x / 25) = (x * Recip25) >> RecipShift for x below 74565
    localparam logic [19:0]      Recip25     = 20'd671089;
    localparam int               RecipShift  = 24;
    localparam logic [DistW-1:0] DistMax     = 22'd4194303;

    localparam logic [MonW-1:0] MonFeb = 4'd2;

    typedef struct packed {
        logic [DayW-1:0]  first_day;
        logic [MonW-1:0]  first_month;
        logic [YearW-1:0] first_year;
        logic [DayW-1:0]  second_day;
        logic [MonW-1:0]  second_month;
        logic [YearW-1:0] second_year;
    } t_gdd_req;

    typedef struct packed {
        logic [DistW-1:0] day_distance;
        logic             date_invalid;
    } t_gdd_res;

    // Month length; zero for codes that are not a month
    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the months before month m in a common year
    function automatic logic [8:0] days_before(input logic [MonW-1:0] m);
        logic [8:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/gdd_date_num.sv]
// Three-stage pipeline turning one date into a day number plus a validity flag.
// Depends on gdd_pkg for widths, reciprocal constants and month tables.
`default_nettype none

module gdd_date_num
    import gdd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [DayW-1:0]  i_day,
    input  wire logic [MonW-1:0]  i_month,
    input  wire logic [YearW-1:0] i_year,
    output logic      [NumW-1:0]  o_num,
    output logic                  o_ok
);

    // Stage 1: shifted year and the two divisions by 25
    logic [YsW-1:0]  n1_ys;
    logic [32:0]     n1_p100;
    logic [33:0]     n1_p25;
    logic [DayW-1:0] r1_d;
    logic [MonW-1:0] r1_m;
    logic [YearW-1:0] r1_y;
    logic [YsW-1:0]  r1_ys;
    logic [7:0]      r1_q100;
    logic [9:0]      r1_q25;

    assign n1_ys   = YsW'(i_year) + YearBias;
    // ys / 100 = (ys / 4) / 25
    assign n1_p100 = 33'(n1_ys[YsW-1:2]) * 33'(Recip25);
    assign n1_p25  = 34'(i_year) * 34'(Recip25);

    always_ff @(posedge i_clk) begin
        r1_d    <= i_day;
        r1_m    <= i_month;
        r1_y    <= i_year;
        r1_ys   <= n1_ys;
        r1_q100 <= n1_p100[RecipShift+7:RecipShift];
        r1_q25  <= n1_p25[RecipShift+9:RecipShift];
    end

    // Stage 2: leap rule, date check, year product and small offset
    logic [YearW-1:0] n2_25q;
    logic             n2_div25;
    logic             n2_leap;
    logic [DayW-1:0]  n2_mlen;
    logic [OffW:0]    n2_off;
    logic [NumW-1:0]  r2_yd;
    logic [OffW-1:0]  r2_off;
    logic             r2_ok;

    assign n2_25q   = {r1_q25, 4'b0} + {1'b0, r1_q25, 3'b0} + YearW'(r1_q25);
    assign n2_div25 = (n2_25q == r1_y);
    // divisible by 4 but not 100, or by 400 (= 16 and 25)
    assign n2_leap  = ((r1_y[1:0] == 2'b0) && !n2_div25)
                   || ((r1_y[3:0] == 4'b0) && n2_div25);
    assign n2_mlen  = month_len(r1_m, n2_leap);
    assign n2_off   = (OffW+1)'(r1_ys[YsW-1:2]) - (OffW+1)'(r1_q100)
                    + (OffW+1)'(r1_q100[7:2]) + (OffW+1)'(days_before(r1_m))
                    + (OffW+1)'((r1_m > MonFeb) && n2_leap) + (OffW+1)'(r1_d);

    always_ff @(posedge i_clk) begin
        r2_yd  <= NumW'(r1_ys) * NumW'(DaysPerYear);
        r2_off <= n2_off[OffW-1:0];
        r2_ok  <= (r1_d != '0) && (r1_d <= n2_mlen);
    end

    // Stage 3: final day number
    logic [NumW-1:0] r3_num;
    logic            r3_ok;

    always_ff @(posedge i_clk) begin
        r3_num <= r2_yd + NumW'(r2_off);
        r3_ok  <= r2_ok;
    end

    assign o_num = r3_num;
    assign o_ok  = r3_ok;

endmodule

`default_nettype wire

[rtl/gregorian_day_difference.sv]
// Top level: two date converters, the difference stage and the valid pipeline.
// Depends on gdd_pkg and gdd_date_num.
`default_nettype none

// Takes one request (two day/month/year dates) per clock whenever i_start is
// high; o_busy is always low. The result appears on o_res with o_valid high
// for one cycle, after three stages of day-number conversion per date
// (divide-by-25 multiplies, then the 365 x year product and month table,
// then the final add) and one stage for the absolute difference. The
// receiver cannot stall; results stream out one per clock.
// A bad month or day on either date sets date_invalid with a distance of 0.
module gregorian_day_difference
    import gdd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_gdd_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output t_gdd_res      o_res
);

    logic [NumW-1:0] w_num_a;
    logic [NumW-1:0] w_num_b;
    logic            w_ok_a;
    logic            w_ok_b;

    gdd_date_num u_date_a (
        .i_clk   (i_clk),
        .i_day   (i_req.first_day),
        .i_month (i_req.first_month),
        .i_year  (i_req.first_year),
        .o_num   (w_num_a),
        .o_ok    (w_ok_a)
    );

    gdd_date_num u_date_b (
        .i_clk   (i_clk),
        .i_day   (i_req.second_day),
        .i_month (i_req.second_month),
        .i_year  (i_req.second_year),
        .o_num   (w_num_b),
        .o_ok    (w_ok_b)
    );

    logic [2:0] r_vld;
    logic       r_out_vld;
    t_gdd_res   r_res;
    logic [NumW-1:0]  n_diff;
    logic [DistW-1:0] n_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[1:0], i_start};
            r_out_vld <= r_vld[2];
        end
    end

    assign n_diff = (w_num_a >= w_num_b) ? (w_num_a - w_num_b) : (w_num_b - w_num_a);
    assign n_dist = (n_diff > NumW'(DistMax)) ? DistMax : n_diff[DistW-1:0];

    always_ff @(posedge i_clk) begin
        r_res.day_distance <= (w_ok_a && w_ok_b) ? n_dist : '0;
        r_res.date_invalid <= !(w_ok_a && w_ok_b);
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_out_vld;
    assign o_res   = r_res;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.date_invalid) |-> (o_res.day_distance == '0))
        else $error("invalid date with nonzero distance");

    a_same_date_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_req.first_day == i_req.second_day
                          && i_req.first_month == i_req.second_month
                          && i_req.first_year == i_req.second_year, 4))
        |-> (o_res.day_distance == '0))
        else $error("equal dates gave nonzero distance");

    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && $past(i_rst_n)) |-> $past(i_start))
        else $error("pipeline valid without a request");

endmodule

`default_nettype wire
